// ===== design/sdpfa_pkg.sv =====
// Shared constants and types of the soft disk pair force accumulator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package sdpfa_pkg;

  localparam int unsigned MAX_DISKS_DEF = 1024;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned FRC_W      = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_PAIR = 2'd1;
  localparam logic [OP_W-1:0] OP_WALL = 2'd2;
  localparam logic [OP_W-1:0] OP_READ = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPRING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_INV = 2'd2;

  localparam logic [31:0] SPRING_RST  = 32'd65536;
  localparam logic [30:0] BOX_LEN_RST = 31'd6553600;
  localparam logic [31:0] BOX_INV_RST = 32'd42949673;

  localparam int unsigned CNT_W      = 6;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 64;

  typedef enum logic [4:0] {
    STEP_NONE, STEP_LATCH, STEP_LOAD, STEP_DRD_I, STEP_DCAP_A_RD_J, STEP_DCAP_B,
    STEP_DCAP_WALL, STEP_MUL_N, STEP_N, STEP_MUL_SH, STEP_SEP, STEP_SQX, STEP_SQY,
    STEP_SQD, STEP_SQRT_INIT, STEP_SQRT, STEP_MUL_NUM, STEP_DIV_INIT, STEP_DIV,
    STEP_CLAMP, STEP_TX_LO, STEP_TX_HI, STEP_TX_SUM, STEP_TY_HI, STEP_TY_SUM,
    STEP_FRD_I, STEP_FWR_I, STEP_FRD_J, STEP_FWR_J, STEP_FRD_OUT, STEP_OUT, STEP_OUTZ
  } step_e;

  typedef struct packed {
    step_e step;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok_i;
    logic            ok_j;
    logic            far;
    logic            miss;
  } dp_stat_t;

endpackage

// ===== design/sdpfa_item_if.sv =====
// Input item channel: valid/ready plus the item fields.
// Depends on sdpfa_pkg for field widths.
interface sdpfa_item_if;
  logic                                valid;
  logic                                ready;
  logic [sdpfa_pkg::OP_W-1:0]          operation;
  logic [sdpfa_pkg::IDX_W-1:0]         disk_index;
  logic [sdpfa_pkg::IDX_W-1:0]         partner_index;
  logic signed [sdpfa_pkg::POS_W-1:0]  pos_x;
  logic signed [sdpfa_pkg::POS_W-1:0]  pos_y;
  logic [sdpfa_pkg::RAD_W-1:0]         radius;

  modport source (output valid, operation, disk_index, partner_index, pos_x, pos_y, radius,
                  input ready);
  modport sink (input valid, operation, disk_index, partner_index, pos_x, pos_y, radius,
                output ready);
endinterface

// ===== design/sdpfa_result_if.sv =====
// Result item channel: valid/ready plus the force readout fields.
// Depends on sdpfa_pkg for field widths.
interface sdpfa_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdpfa_pkg::FRC_W-1:0]  force_x;
  logic signed [sdpfa_pkg::FRC_W-1:0]  force_y;
  logic                                saturated;

  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink (input valid, force_x, force_y, saturated, output ready);
endinterface

// ===== design/sdpfa_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on sdpfa_pkg for field widths.
interface sdpfa_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sdpfa_pkg::CFG_IDX_W-1:0]    index;
  logic [sdpfa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/sdpfa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sdpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sdpfa_ctrl.sv =====
// Sequencer for the force accumulator: walks each item through datapath steps.
// Depends on sdpfa_pkg for the step codes and the command/status structs.
module sdpfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  input  sdpfa_pkg::dp_stat_t stat_i,
  output sdpfa_pkg::dp_cmd_t  cmd_o
);
  import sdpfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_DRD_I, S_DCAP_A_RD_J, S_DCAP_B, S_DCAP_WALL,
    S_MUL_N, S_N, S_MUL_SH, S_SEP, S_SQX, S_SQY, S_SQD, S_SQRT_INIT, S_SQRT,
    S_MUL_NUM, S_DIV_INIT, S_DIV, S_CLAMP, S_TX_LO, S_TX_HI, S_TX_SUM, S_TY_HI,
    S_TY_SUM, S_FRD_I, S_FWR_I, S_FRD_J, S_FWR_J, S_FRD_OUT, S_OUT, S_OUTZ
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             free;
  step_e            step;

  assign free = !out_valid_q || result_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    step        = STEP_NONE;
    if (out_valid_q && result_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          step    = STEP_LATCH;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_LOAD: state_d = stat_i.ok_i ? S_LOAD : S_IDLE;
          OP_PAIR: state_d = (stat_i.ok_i && stat_i.ok_j) ? S_DRD_I : S_IDLE;
          OP_WALL: state_d = stat_i.ok_i ? S_DRD_I : S_IDLE;
          OP_READ: state_d = stat_i.ok_i ? S_FRD_OUT : S_OUTZ;
          default: state_d = S_IDLE;
        endcase
      end
      S_LOAD: begin
        step    = STEP_LOAD;
        state_d = S_IDLE;
      end
      S_DRD_I: begin
        step    = STEP_DRD_I;
        state_d = (stat_i.op == OP_PAIR) ? S_DCAP_A_RD_J : S_DCAP_WALL;
      end
      S_DCAP_A_RD_J: begin
        step    = STEP_DCAP_A_RD_J;
        state_d = S_DCAP_B;
      end
      S_DCAP_B: begin
        step    = STEP_DCAP_B;
        state_d = S_MUL_N;
      end
      S_DCAP_WALL: begin
        step    = STEP_DCAP_WALL;
        state_d = S_MUL_N;
      end
      S_MUL_N: begin
        step    = STEP_MUL_N;
        state_d = S_N;
      end
      S_N: begin
        step    = STEP_N;
        state_d = S_MUL_SH;
      end
      S_MUL_SH: begin
        step    = STEP_MUL_SH;
        state_d = S_SEP;
      end
      S_SEP: begin
        step    = STEP_SEP;
        state_d = S_SQX;
      end
      S_SQX: begin
        // separation already beyond the radius sum on one axis: no contact
        step    = STEP_SQX;
        state_d = stat_i.far ? S_IDLE : S_SQY;
      end
      S_SQY: begin
        step    = STEP_SQY;
        state_d = S_SQD;
      end
      S_SQD: begin
        step    = STEP_SQD;
        state_d = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        step    = STEP_SQRT_INIT;
        cnt_d   = '0;
        state_d = stat_i.miss ? S_IDLE : S_SQRT;
      end
      S_SQRT: begin
        step  = STEP_SQRT;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = S_MUL_NUM;
        end
      end
      S_MUL_NUM: begin
        step    = STEP_MUL_NUM;
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        step    = STEP_DIV_INIT;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        step  = STEP_DIV;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        step    = STEP_CLAMP;
        state_d = S_TX_LO;
      end
      S_TX_LO: begin
        step    = STEP_TX_LO;
        state_d = S_TX_HI;
      end
      S_TX_HI: begin
        step    = STEP_TX_HI;
        state_d = S_TX_SUM;
      end
      S_TX_SUM: begin
        step    = STEP_TX_SUM;
        state_d = S_TY_HI;
      end
      S_TY_HI: begin
        step    = STEP_TY_HI;
        state_d = S_TY_SUM;
      end
      S_TY_SUM: begin
        step    = STEP_TY_SUM;
        state_d = S_FRD_I;
      end
      S_FRD_I: begin
        step    = STEP_FRD_I;
        state_d = S_FWR_I;
      end
      S_FWR_I: begin
        step    = STEP_FWR_I;
        state_d = (stat_i.op == OP_PAIR) ? S_FRD_J : S_IDLE;
      end
      S_FRD_J: begin
        step    = STEP_FRD_J;
        state_d = S_FWR_J;
      end
      S_FWR_J: begin
        step    = STEP_FWR_J;
        state_d = S_IDLE;
      end
      S_FRD_OUT: begin
        step    = STEP_FRD_OUT;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (free) begin
          step        = STEP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_OUTZ: begin
        if (free) begin
          step        = STEP_OUTZ;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign item_ready_o   = (state_q == S_IDLE);
  assign result_valid_o = out_valid_q;
  assign cmd_o.step     = step;

endmodule

// ===== design/sdpfa_dp.sv =====
// Datapath: disk and force memories, config registers, shared 32x32 multiplier,
// bit-serial square root and divider. Depends on sdpfa_pkg and sdpfa_ram.
module sdpfa_dp #(
  parameter int unsigned MAX_DISKS = sdpfa_pkg::MAX_DISKS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sdpfa_pkg::OP_W-1:0]          operation_i,
  input  logic [sdpfa_pkg::IDX_W-1:0]         disk_index_i,
  input  logic [sdpfa_pkg::IDX_W-1:0]         partner_index_i,
  input  logic signed [sdpfa_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [sdpfa_pkg::POS_W-1:0]  pos_y_i,
  input  logic [sdpfa_pkg::RAD_W-1:0]         radius_i,
  input  logic                                cfg_valid_i,
  input  logic [sdpfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sdpfa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  sdpfa_pkg::dp_cmd_t                  cmd_i,
  output sdpfa_pkg::dp_stat_t                 stat_o,
  output logic signed [sdpfa_pkg::FRC_W-1:0]  force_x_o,
  output logic signed [sdpfa_pkg::FRC_W-1:0]  force_y_o,
  output logic                                saturated_o
);
  import sdpfa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DISKS);
  localparam int unsigned DW = 2 * POS_W + RAD_W;
  localparam int unsigned FW = 2 * FRC_W + 1;
  localparam logic [FRC_W-1:0] FRC_MAX = {1'b0, {(FRC_W-1){1'b1}}};
  localparam logic [FRC_W-1:0] FRC_MIN = {1'b1, {(FRC_W-1){1'b0}}};
  localparam logic [65:0] HALF_N = 66'd1 << 47;

  // {clip, saturated sum}
  function automatic logic [FRC_W:0] sat_add(input logic [FRC_W-1:0] acc,
                                             input logic [FRC_W-1:0] t);
    logic [FRC_W:0] s;
    s = {acc[FRC_W-1], acc} + {t[FRC_W-1], t};
    if (s[FRC_W] != s[FRC_W-1]) begin
      return {1'b1, s[FRC_W] ? FRC_MIN : FRC_MAX};
    end
    return {1'b0, s[FRC_W-1:0]};
  endfunction

  // {clip, magnitude} of (hi*2^32 + lo) >> 16, clamped to 2^47-1
  function automatic logic [FRC_W-1:0] term_mag(input logic [63:0] hi,
                                                input logic [63:0] lo);
    logic [80:0] t;
    logic [64:0] m;
    t = {1'b0, hi[47:0], 32'd0} + {17'd0, lo};
    m = t[80:16];
    if (|m[64:47]) begin
      return {1'b1, FRC_MAX[FRC_W-2:0]};
    end
    return {1'b0, m[46:0]};
  endfunction

  step_e step;
  assign step = cmd_i.step;

  // configuration
  logic [31:0] k_q;
  logic [30:0] len_q;
  logic [31:0] inv_q;

  // latched item
  logic [OP_W-1:0]         op_q;
  logic                    ok_i_q, ok_j_q;
  logic [AW-1:0]           idx_i_q, idx_j_q;
  logic signed [POS_W-1:0] px_q, py_q;
  logic [RAD_W-1:0]        pr_q;

  // the two disks
  logic signed [POS_W-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic [RAD_W-1:0]        a_r_q, b_r_q;

  logic [63:0] prod_q, acc_q;
  logic [16:0] n_q;
  logic [48:0] sepx_q;
  logic [32:0] sepy_q;
  logic        sx_neg_q, sy_neg_q;
  logic [31:0] d_q;
  logic [64:0] sum_q;
  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [63:0] dnum_q;
  logic [31:0] drem_q;
  logic [47:0] fr_q;
  logic [46:0] tx_q, ty_q;
  logic        clip_q;
  logic signed [FRC_W-1:0] out_fx_q, out_fy_q;
  logic        out_sat_q;

  // memories
  logic          disk_we, disk_re;
  logic [AW-1:0] disk_raddr;
  logic [DW-1:0] disk_rdata;
  logic          frc_we, frc_re;
  logic [AW-1:0] frc_waddr, frc_raddr;
  logic [FW-1:0] frc_wdata, frc_rdata;

  logic signed [POS_W-1:0] rd_x, rd_y;
  logic [RAD_W-1:0]        rd_r;

  assign rd_x = disk_rdata[DW-1 -: POS_W];
  assign rd_y = disk_rdata[RAD_W +: POS_W];
  assign rd_r = disk_rdata[RAD_W-1:0];

  assign disk_we    = (step == STEP_LOAD);
  assign disk_re    = (step == STEP_DRD_I) || (step == STEP_DCAP_A_RD_J);
  assign disk_raddr = (step == STEP_DRD_I) ? idx_i_q : idx_j_q;

  sdpfa_ram #(.WIDTH(DW), .DEPTH(MAX_DISKS)) u_disk_ram (
    .clk_i   (clk_i),
    .we_i    (disk_we),
    .waddr_i (idx_i_q),
    .wdata_i ({px_q, py_q, pr_q}),
    .re_i    (disk_re),
    .raddr_i (disk_raddr),
    .rdata_o (disk_rdata)
  );

  // separation arithmetic
  logic [32:0] dx, mag, sy;
  logic        dneg;
  logic [65:0] nsum;
  logic [49:0] sx50, sx_abs;
  logic [32:0] sy_abs;

  assign dx     = {a_x_q[POS_W-1], a_x_q} - {b_x_q[POS_W-1], b_x_q};
  assign dneg   = dx[32];
  assign mag    = dneg ? (~dx + 33'd1) : dx;
  assign nsum   = {2'b00, prod_q} + (mag[32] ? {2'b00, inv_q, 32'd0} : 66'd0) + HALF_N;
  assign sx50   = dneg ? ({{17{dx[32]}}, dx} + {2'b00, prod_q[47:0]})
                       : ({{17{dx[32]}}, dx} - {2'b00, prod_q[47:0]});
  assign sx_abs = sx50[49] ? (~sx50 + 50'd1) : sx50;
  assign sy     = {a_y_q[POS_W-1], a_y_q} - {b_y_q[POS_W-1], b_y_q};
  assign sy_abs = sy[32] ? (~sy + 33'd1) : sy;

  // square root step: two radicand bits per cycle
  logic [34:0] rem_n, trial;
  assign rem_n = {rem_q[32:0], rad_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};

  logic [31:0] r_val;
  assign r_val = (root_q == 32'd0) ? 32'd1 : root_q;

  // restoring divide step
  logic [32:0] drem_n;
  assign drem_n = {drem_q, dnum_q[63]};

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic        mul_en;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (step)
      STEP_MUL_N: begin
        mul_a = mag[31:0];
        mul_b = inv_q;
      end
      STEP_MUL_SH: begin
        mul_a = {15'd0, n_q};
        mul_b = {1'b0, len_q};
      end
      STEP_SQX: begin
        mul_a = sepx_q[31:0];
        mul_b = sepx_q[31:0];
      end
      STEP_SQY: begin
        mul_a = sepy_q[31:0];
        mul_b = sepy_q[31:0];
      end
      STEP_SQD: begin
        mul_a = d_q;
        mul_b = d_q;
      end
      STEP_MUL_NUM: begin
        mul_a = k_q;
        mul_b = d_q - r_val;
      end
      STEP_TX_LO: begin
        mul_a = fr_q[31:0];
        mul_b = sepx_q[31:0];
      end
      STEP_TX_HI: begin
        mul_a = {16'd0, fr_q[47:32]};
        mul_b = sepx_q[31:0];
      end
      STEP_TX_SUM: begin
        mul_a = fr_q[31:0];
        mul_b = sepy_q[31:0];
      end
      STEP_TY_HI: begin
        mul_a = {16'd0, fr_q[47:32]};
        mul_b = sepy_q[31:0];
      end
      default: mul_en = 1'b0;
    endcase
  end

  // signed force terms on disk i
  logic [FRC_W-1:0] fx, fy;
  assign fx = sx_neg_q ? (48'd0 - {1'b0, tx_q}) : {1'b0, tx_q};
  assign fy = sy_neg_q ? (48'd0 - {1'b0, ty_q}) : {1'b0, ty_q};

  logic [FRC_W-1:0] old_fx, old_fy, add_x, add_y;
  logic             old_clip;
  logic [FRC_W:0]   new_x, new_y;
  logic [FRC_W-1:0] term;

  assign old_fx   = frc_rdata[FW-1 -: FRC_W];
  assign old_fy   = frc_rdata[1 +: FRC_W];
  assign old_clip = frc_rdata[0];
  assign add_x    = (step == STEP_FWR_J) ? (48'd0 - fx) : fx;
  assign add_y    = (step == STEP_FWR_J) ? (48'd0 - fy) : fy;
  assign new_x    = sat_add(old_fx, add_x);
  assign new_y    = sat_add(old_fy, add_y);
  assign term     = term_mag(prod_q, acc_q);

  assign frc_we    = (step == STEP_LOAD) || (step == STEP_FWR_I) || (step == STEP_FWR_J);
  assign frc_waddr = (step == STEP_FWR_J) ? idx_j_q : idx_i_q;
  assign frc_wdata = (step == STEP_LOAD) ? '0
                   : {new_x[FRC_W-1:0], new_y[FRC_W-1:0],
                      old_clip | clip_q | new_x[FRC_W] | new_y[FRC_W]};
  assign frc_re    = (step == STEP_FRD_I) || (step == STEP_FRD_J) || (step == STEP_FRD_OUT);
  assign frc_raddr = (step == STEP_FRD_J) ? idx_j_q : idx_i_q;

  sdpfa_ram #(.WIDTH(FW), .DEPTH(MAX_DISKS)) u_force_ram (
    .clk_i   (clk_i),
    .we_i    (frc_we),
    .waddr_i (frc_waddr),
    .wdata_i (frc_wdata),
    .re_i    (frc_re),
    .raddr_i (frc_raddr),
    .rdata_o (frc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= SPRING_RST;
      len_q <= BOX_LEN_RST;
      inv_q <= BOX_INV_RST;
      op_q  <= OP_LOAD;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SPRING:  k_q   <= cfg_data_i;
          CFG_BOX_LEN: len_q <= cfg_data_i[30:0];
          CFG_BOX_INV: inv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (step == STEP_LATCH) begin
        op_q <= operation_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
    end
    case (step)
      STEP_LATCH: begin
        ok_i_q  <= (32'(disk_index_i) < MAX_DISKS);
        ok_j_q  <= (32'(partner_index_i) < MAX_DISKS);
        idx_i_q <= AW'(disk_index_i);
        idx_j_q <= AW'(partner_index_i);
        px_q    <= pos_x_i;
        py_q    <= pos_y_i;
        pr_q    <= radius_i;
        clip_q  <= 1'b0;
      end
      STEP_DCAP_A_RD_J: begin
        a_x_q <= rd_x;
        a_y_q <= rd_y;
        a_r_q <= rd_r;
      end
      STEP_DCAP_B: begin
        b_x_q <= rd_x;
        b_y_q <= rd_y;
        b_r_q <= rd_r;
      end
      STEP_DCAP_WALL: begin
        a_x_q <= rd_x;
        a_y_q <= rd_y;
        a_r_q <= rd_r;
        b_x_q <= px_q;
        b_y_q <= py_q;
        b_r_q <= pr_q;
      end
      STEP_N: n_q <= nsum[64:48];
      STEP_SEP: begin
        sx_neg_q <= sx50[49];
        sepx_q   <= sx_abs[48:0];
        sy_neg_q <= sy[32];
        sepy_q   <= sy_abs;
        d_q      <= {1'b0, a_r_q} + {1'b0, b_r_q};
      end
      STEP_SQY: sum_q <= {1'b0, prod_q};
      STEP_SQD: sum_q <= sum_q + {1'b0, prod_q};
      STEP_SQRT_INIT: begin
        rad_q  <= sum_q[63:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      STEP_SQRT: begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      STEP_DIV_INIT: begin
        dnum_q <= prod_q;
        drem_q <= '0;
      end
      STEP_DIV: begin
        // quotient bits shift in where numerator bits leave
        if (drem_n >= {1'b0, r_val}) begin
          drem_q <= 32'(drem_n - {1'b0, r_val});
          dnum_q <= {dnum_q[62:0], 1'b1};
        end else begin
          drem_q <= drem_n[31:0];
          dnum_q <= {dnum_q[62:0], 1'b0};
        end
      end
      STEP_CLAMP: fr_q <= (|dnum_q[63:48]) ? '1 : dnum_q[47:0];
      STEP_TX_HI: acc_q <= prod_q;
      STEP_TX_SUM: begin
        tx_q   <= term[46:0];
        clip_q <= clip_q | term[47];
      end
      STEP_TY_HI: acc_q <= prod_q;
      STEP_TY_SUM: begin
        ty_q   <= term[46:0];
        clip_q <= clip_q | term[47];
      end
      STEP_OUT: begin
        out_fx_q  <= old_fx;
        out_fy_q  <= old_fy;
        out_sat_q <= old_clip;
      end
      STEP_OUTZ: begin
        out_fx_q  <= '0;
        out_fy_q  <= '0;
        out_sat_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign stat_o.op   = op_q;
  assign stat_o.ok_i = ok_i_q;
  assign stat_o.ok_j = ok_j_q;
  assign stat_o.far  = (sepx_q >= {17'd0, d_q}) || (sepy_q >= {1'b0, d_q});
  assign stat_o.miss = (sum_q >= {1'b0, prod_q}) || (sum_q == 65'd0);

  assign force_x_o   = out_fx_q;
  assign force_y_o   = out_fy_q;
  assign saturated_o = out_sat_q;

endmodule

// ===== design/soft_disk_pair_force_accumulator.sv =====
// Top level of the soft disk pair force accumulator: sequencer plus datapath.
// Depends on sdpfa_pkg, the three channel interfaces, sdpfa_ctrl and sdpfa_dp.
//
//   channel     dir  handshake     payload
//   items_i     in   valid/ready   operation, disk_index, partner_index, pos_x, pos_y, radius
//   results_o   out  valid/ready   force_x, force_y, saturated
//   cfg_i       in   valid/ready   index, data (ready always high)
//
// One item at a time. Pair and wall interactions use the 32-step square root
// and the 64-step divider, one bit per cycle each, plus one shared 32x32 multiplier.
// Reset clears control and config only; disk and force memories hold garbage until loaded.
// A read waits for the result register to empty; new items are taken while it holds.
module soft_disk_pair_force_accumulator #(
  parameter int unsigned MAX_DISKS = sdpfa_pkg::MAX_DISKS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  sdpfa_item_if.sink  items_i,
  sdpfa_result_if.source results_o,
  sdpfa_cfg_if.sink   cfg_i
);
  import sdpfa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  sdpfa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (items_i.valid),
    .item_ready_o   (items_i.ready),
    .result_valid_o (results_o.valid),
    .result_ready_i (results_o.ready),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  sdpfa_dp #(.MAX_DISKS(MAX_DISKS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (items_i.operation),
    .disk_index_i    (items_i.disk_index),
    .partner_index_i (items_i.partner_index),
    .pos_x_i         (items_i.pos_x),
    .pos_y_i         (items_i.pos_y),
    .radius_i        (items_i.radius),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .force_x_o       (results_o.force_x),
    .force_y_o       (results_o.force_y),
    .saturated_o     (results_o.saturated)
  );

endmodule
